>>> sv/mlfd_pkg.sv
// Shared constants and types of the magic-length frame deframer.
`default_nettype none

package mlfd_pkg;

    localparam int HDR_LEN = 7;

    localparam logic [7:0]  MAGIC_FIRST       = 8'hAA;
    localparam logic [7:0]  MAGIC_SECOND      = 8'h55;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4194304;

    localparam int          APB_ADDR_W       = 3;
    localparam logic        REG_MAX_PAYLOAD  = 1'b0;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        EVT_PAYLOAD  = 2'd0,
        EVT_EMPTY    = 2'd1,
        EVT_OVERSIZE = 2'd2
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind   event_kind;
        t_byte       frame_type;
        t_byte       payload_byte;
        logic [31:0] frame_length;
        logic        last_byte;
    } t_evt;

endpackage

`default_nettype wire

>>> sv/mlfd_ifs.sv
// Stream interfaces for received bytes and for deframer events.
`default_nettype none

interface mlfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       new_session;

    modport source (output valid, output rx_byte, output new_session, input ready);
    modport sink   (input valid, input rx_byte, input new_session, output ready);
endinterface

interface mlfd_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic [31:0] frame_length;
    logic        last_byte;

    modport source (output valid, output event_kind, output frame_type, output payload_byte,
                    output frame_length, output last_byte, input ready);
    modport sink   (input valid, input event_kind, input frame_type, input payload_byte,
                    input frame_length, input last_byte, output ready);
endinterface

`default_nettype wire

>>> sv/mlfd_regs.sv
// APB register block holding the maximum payload length.
`default_nettype none

module mlfd_regs
    import mlfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready,
    output      logic [31:0]           o_max_payload
);

    logic [31:0] r_max_payload;
    logic        wr_max;

    assign pready = 1'b1;
    assign wr_max = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (wr_max) begin
            r_max_payload <= pwdata;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_PAYLOAD) begin
            prdata = r_max_payload;
        end
    end

    assign o_max_payload = r_max_payload;

endmodule

`default_nettype wire

>>> sv/mlfd_core.sv
// Input register, header window and payload tracking of the deframer.
`default_nettype none

module mlfd_core
    import mlfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mlfd_rx_if.sink          i_rx,
    input  wire logic [31:0] i_max_payload,
    input  wire logic        i_room,
    output      logic        o_res_valid,
    output      t_evt        o_res
);

    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        r_in_ns;

    t_byte       r_win [HDR_LEN];
    logic [2:0]  r_hdr_cnt;
    logic        r_in_payload;
    logic [31:0] r_remaining;
    t_byte       r_cur_type;
    logic [31:0] r_cur_len;

    t_byte       n_win [HDR_LEN];
    logic [2:0]  n_hdr_cnt;
    logic        n_in_payload;
    logic [31:0] n_remaining;
    t_byte       n_cur_type;
    logic [31:0] n_cur_len;

    logic        proc;
    logic        take;

    assign proc       = r_in_valid && i_room;
    assign i_rx.ready = !r_in_valid || i_room;
    assign take       = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_ns   <= i_rx.new_session;
        end
    end

    always_comb begin
        logic [2:0]  cnt;
        logic        busy;
        logic [31:0] rem;
        logic [31:0] len;

        for (int i = 0; i < HDR_LEN; i++) begin
            n_win[i] = r_in_ns ? 8'd0 : r_win[i];
        end
        cnt  = r_in_ns ? 3'd0 : r_hdr_cnt;
        busy = r_in_ns ? 1'b0 : r_in_payload;
        rem  = r_in_ns ? 32'd0 : r_remaining;
        len  = 32'd0;

        n_hdr_cnt    = cnt;
        n_in_payload = busy;
        n_remaining  = rem;
        n_cur_type   = r_cur_type;
        n_cur_len    = r_cur_len;
        o_res_valid  = 1'b0;

        if (busy) begin
            n_remaining = rem - 32'd1;
            o_res_valid = 1'b1;
            if (rem == 32'd1) begin
                n_in_payload = 1'b0;
                n_hdr_cnt    = 3'd0;
            end
        end else begin
            if (cnt > 3'(HDR_LEN - 1)) begin
                cnt = 3'd0;
            end
            for (int i = 0; i < HDR_LEN; i++) begin
                if (cnt == 3'(i)) begin
                    n_win[i] = r_in_byte;
                end
            end
            if (cnt != 3'(HDR_LEN - 1)) begin
                n_hdr_cnt = cnt + 3'd1;
            end else if (n_win[0] != MAGIC_FIRST || n_win[1] != MAGIC_SECOND) begin
                for (int i = 0; i < HDR_LEN - 1; i++) begin
                    n_win[i] = n_win[i + 1];
                end
                n_win[HDR_LEN - 1] = 8'd0;
                n_hdr_cnt          = 3'(HDR_LEN - 1);
            end else begin
                len        = {n_win[3], n_win[4], n_win[5], n_win[6]};
                n_cur_type = n_win[2];
                n_cur_len  = len;
                n_hdr_cnt  = 3'd0;
                if (len > i_max_payload || len == 32'd0) begin
                    o_res_valid = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                    n_remaining  = len;
                end
            end
        end
        o_res_valid = o_res_valid && proc;

        o_res.frame_type   = n_cur_type;
        o_res.frame_length = n_cur_len;
        if (busy) begin
            o_res.event_kind   = EVT_PAYLOAD;
            o_res.payload_byte = r_in_byte;
            o_res.last_byte    = (rem == 32'd1);
        end else begin
            o_res.event_kind   = (len == 32'd0) ? EVT_EMPTY : EVT_OVERSIZE;
            o_res.payload_byte = 8'd0;
            o_res.last_byte    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HDR_LEN; i++) begin
                r_win[i] <= 8'd0;
            end
            r_hdr_cnt    <= 3'd0;
            r_in_payload <= 1'b0;
            r_remaining  <= 32'd0;
            r_cur_type   <= 8'd0;
            r_cur_len    <= 32'd0;
        end else if (proc) begin
            r_win        <= n_win;
            r_hdr_cnt    <= n_hdr_cnt;
            r_in_payload <= n_in_payload;
            r_remaining  <= n_remaining;
            r_cur_type   <= n_cur_type;
            r_cur_len    <= n_cur_len;
        end
    end

endmodule

`default_nettype wire

>>> sv/mlfd_out_buf.sv
// Two-entry result buffer that drives the event channel.
`default_nettype none

module mlfd_out_buf
    import mlfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_evt i_data,
    output      logic o_room,
    mlfd_evt_if.source o_evt
);

    t_evt       r_buf [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       pop;
    t_evt       head;

    assign o_room = (r_cnt != 2'd2);
    assign pop    = o_evt.valid && o_evt.ready;
    assign head   = r_buf[r_rd];

    assign o_evt.valid        = (r_cnt != 2'd0);
    assign o_evt.event_kind   = head.event_kind;
    assign o_evt.frame_type   = head.frame_type;
    assign o_evt.payload_byte = head.payload_byte;
    assign o_evt.frame_length = head.frame_length;
    assign o_evt.last_byte    = head.last_byte;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/magic_length_frame_deframer.sv
// Top level of the magic-length frame deframer.
//
//   Channel   Direction  Carries
//   i_rx      in         rx_byte, new_session
//   o_evt     out        event_kind, frame_type, payload_byte, frame_length, last_byte
//   APB       in/out     max_payload_bytes at byte address 0
//
// One byte is taken per cycle while the result buffer has room; an accepted byte is held
// in the input register, and its event, if any, goes from there into the result buffer that drives o_evt.
// The rate is set by the combinational header and payload update in mlfd_core.
// Reset is synchronous and active low; no clearing pass is needed.
// A two-entry result buffer lets input continue while one event waits downstream.
`default_nettype none

module magic_length_frame_deframer
    import mlfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mlfd_rx_if.sink                    i_rx,
    mlfd_evt_if.source                 o_evt,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready
);

    logic [31:0] max_payload;
    logic        room;
    logic        res_valid;
    t_evt        res;

    mlfd_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (max_payload)
    );

    mlfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (i_rx),
        .i_max_payload (max_payload),
        .i_room        (room),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    mlfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_evt   (o_evt)
    );

endmodule

`default_nettype wire

>>> sv/mlfd_checker.sv
// Port-level assertions for the deframer and their binding to the top level.
`default_nettype none

module mlfd_checker
    import mlfd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_event_kind,
    input wire logic [7:0]  i_payload_byte,
    input wire logic [31:0] i_frame_length,
    input wire logic        i_last_byte,
    input wire logic        i_psel,
    input wire logic        i_penable,
    input wire logic        i_pwrite,
    input wire logic [2:0]  i_paddr,
    input wire logic [31:0] i_pwdata,
    input wire logic [31:0] i_prdata
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("event request dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_event_kind) && $stable(i_payload_byte) && $stable(i_frame_length))
        else $error("event request changed while stalled");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("outputs not idle after reset");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_byte |-> i_event_kind == EVT_PAYLOAD)
        else $error("last byte flag on a non-payload event");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_paddr[2] == REG_MAX_PAYLOAD |=>
            (i_paddr[2] != REG_MAX_PAYLOAD) || (i_prdata == $past(i_pwdata)))
        else $error("register readback does not match the last write");

endmodule

bind magic_length_frame_deframer mlfd_checker u_mlfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_evt.valid),
    .i_out_ready    (o_evt.ready),
    .i_event_kind   (o_evt.event_kind),
    .i_payload_byte (o_evt.payload_byte),
    .i_frame_length (o_evt.frame_length),
    .i_last_byte    (o_evt.last_byte),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);

`default_nettype wire

>>> verif/magic_length_frame_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the deframer: random framed byte streams against a built-in predictor.
module magic_length_frame_deframer_tb;
    import mlfd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = APB_ADDR_W'(4 * int'(REG_MAX_PAYLOAD));

    typedef struct {
        t_byte data;
        logic  new_session;
        int    gap;
    } t_rx_req;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    mlfd_rx_if  rx_if();
    mlfd_evt_if evt_if();

    magic_length_frame_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_evt   (evt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_rx_req     pending_bytes[$];
    t_evt        expected_events[$];
    t_rx_req     rx_next;
    t_evt        evt_seen;
    t_evt        evt_want;
    int          rx_gap;
    int          evt_stall;
    bit          evt_busy;
    bit          rx_busy;
    bit          resync;
    bit          pressure_go;
    logic        hold_off;
    int          errors;
    int          queued_count;
    int          cycle_count;

    // Predictor state.
    logic [31:0] max_len_cfg;
    t_byte       win[HDR_LEN];
    int          hdr_cnt;
    logic        in_pay;
    logic [31:0] remaining;
    t_byte       cur_type;
    logic [31:0] cur_len;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_idle(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic deframe_byte(input t_byte b, input logic ns);
        t_evt        ev;
        logic [31:0] len;
        ev = '0;
        if (ns) begin
            win = '{default: '0};
            hdr_cnt = 0;
            in_pay = 1'b0;
            remaining = '0;
        end
        if (in_pay) begin
            remaining = remaining - 1;
            ev.event_kind = EVT_PAYLOAD;
            ev.frame_type = cur_type;
            ev.payload_byte = b;
            ev.frame_length = cur_len;
            ev.last_byte = (remaining == 0);
            if (remaining == 0) begin
                in_pay = 1'b0;
                hdr_cnt = 0;
            end
            expected_events.push_back(ev);
            return;
        end
        if (hdr_cnt >= HDR_LEN)
            hdr_cnt = 0;
        win[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt < HDR_LEN)
            return;
        if (win[0] != MAGIC_FIRST || win[1] != MAGIC_SECOND) begin
            for (int i = 0; i < HDR_LEN - 1; i++)
                win[i] = win[i + 1];
            win[HDR_LEN - 1] = '0;
            hdr_cnt = HDR_LEN - 1;
            return;
        end
        len = {win[3], win[4], win[5], win[6]};
        cur_type = win[2];
        cur_len = len;
        hdr_cnt = 0;
        ev.frame_type = cur_type;
        ev.frame_length = cur_len;
        if (len > max_len_cfg) begin
            ev.event_kind = EVT_OVERSIZE;
            expected_events.push_back(ev);
        end else if (len == 0) begin
            ev.event_kind = EVT_EMPTY;
            expected_events.push_back(ev);
        end else begin
            in_pay = 1'b1;
            remaining = len;
        end
    endtask

    // Byte source.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_if.ready) begin
            if (rx_gap > 0) begin
                rx_gap--;
                rx_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                rx_next = pending_bytes.pop_front();
                rx_if.valid <= 1'b1;
                rx_if.rx_byte <= rx_next.data;
                rx_if.new_session <= rx_next.new_session;
                rx_gap = rx_next.gap;
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready)
            deframe_byte(rx_if.rx_byte, rx_if.new_session);
    end

    // Event sink and checker.
    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            evt_seen = t_evt'({evt_if.event_kind, evt_if.frame_type, evt_if.payload_byte,
                               evt_if.frame_length, evt_if.last_byte});
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event kind=%0d type=%h byte=%h len=%h last=%b",
                         $time, evt_seen.event_kind, evt_seen.frame_type,
                         evt_seen.payload_byte, evt_seen.frame_length, evt_seen.last_byte);
            end else begin
                evt_want = expected_events.pop_front();
                if (evt_seen !== evt_want) begin
                    errors++;
                    $display("%0t: event mismatch: expected kind=%0d type=%h byte=%h len=%h last=%b",
                             $time, evt_want.event_kind, evt_want.frame_type,
                             evt_want.payload_byte, evt_want.frame_length, evt_want.last_byte);
                    $display("%0t:                 actual   kind=%0d type=%h byte=%h len=%h last=%b",
                             $time, evt_seen.event_kind, evt_seen.frame_type,
                             evt_seen.payload_byte, evt_seen.frame_length, evt_seen.last_byte);
                end
            end
        end
        if ($urandom_range(0, 199) == 0)
            evt_busy = !evt_busy;
        if (!i_rst_n || hold_off) begin
            evt_if.ready <= 1'b0;
        end else if (evt_stall > 0) begin
            evt_stall--;
            evt_if.ready <= 1'b0;
        end else begin
            evt_if.ready <= 1'b1;
            evt_stall = ($urandom_range(0, 5) == 0) ? pick_idle(evt_busy) : 0;
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic push_byte(input t_byte b, input logic ns);
        t_rx_req req;
        req.data = b;
        req.new_session = ns;
        req.gap = pick_idle(rx_busy);
        pending_bytes.push_back(req);
        queued_count++;
    endtask

    task automatic queue_frame(input logic ns, input t_byte ftype, input logic [31:0] len,
                               input int n_payload);
        push_byte(MAGIC_FIRST, ns);
        push_byte(MAGIC_SECOND, 1'b0);
        push_byte(ftype, 1'b0);
        push_byte(len[31:24], 1'b0);
        push_byte(len[23:16], 1'b0);
        push_byte(len[15:8], 1'b0);
        push_byte(len[7:0], 1'b0);
        for (int i = 0; i < n_payload; i++)
            push_byte(t_byte'($urandom), 1'b0);
    endtask

    function automatic logic [31:0] pick_len();
        logic [31:0] cap;
        int          r;
        cap = (max_len_cfg < 16) ? max_len_cfg : 32'd16;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (max_len_cfg != '1 && (r < 30 || cap == 0)) begin
            if (r < 20)
                return max_len_cfg + 1;
            return $urandom_range(32'hFFFF_FFFF, max_len_cfg + 1);
        end
        if (r < 38)
            return cap;
        return $urandom_range(cap, 1);
    endfunction

    task automatic queue_random(input int n_items);
        int          start;
        int          kind;
        int          n;
        int          lim;
        logic        ns;
        logic [31:0] len;
        start = queued_count;
        resync = 1'b1;
        while (queued_count - start < n_items) begin
            if ($urandom_range(0, 11) == 0)
                rx_busy = !rx_busy;
            kind = $urandom_range(0, 99);
            ns = resync || ($urandom_range(0, 19) == 0);
            resync = 1'b0;
            if (kind < 60) begin
                len = pick_len();
                queue_frame(ns, t_byte'($urandom), len, (len > max_len_cfg) ? 0 : int'(len));
            end else if (kind < 75 && max_len_cfg >= 2) begin
                if ($urandom_range(0, 1))
                    len = $urandom_range(max_len_cfg, 2);
                else
                    len = $urandom_range((max_len_cfg < 40) ? max_len_cfg : 32'd40, 2);
                lim = (len > 13) ? 12 : int'(len) - 1;
                queue_frame(ns, t_byte'($urandom), len, $urandom_range(lim, 0));
                resync = 1'b1;
            end else if (kind < 85) begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                    push_byte(t_byte'($urandom), (i == 0) ? ns : 1'b0);
                resync = 1'b1;
            end else if (kind < 95) begin
                n = $urandom_range(2, 1);
                for (int i = 0; i < n; i++)
                    push_byte(t_byte'($urandom), (i == 0) ? ns : 1'b0);
                len = pick_len();
                queue_frame(1'b0, t_byte'($urandom), len, (len > max_len_cfg) ? 0 : int'(len));
                resync = 1'b1;
            end else begin
                n = $urandom_range(6, 1);
                push_byte(MAGIC_FIRST, ns);
                for (int i = 1; i < n; i++)
                    push_byte((i == 1) ? MAGIC_SECOND : t_byte'($urandom), 1'b0);
                resync = 1'b1;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || rx_if.valid || expected_events.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MAX_LEN_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_max_len();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== max_len_cfg) begin
            errors++;
            $display("%0t: max_payload_bytes readback: expected %h, actual %h",
                     $time, max_len_cfg, rd);
        end
    endtask

    task automatic set_max_len(input logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, val, rd);
        max_len_cfg = val;
        check_max_len();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        rx_if.new_session = 1'b0;
        evt_if.ready = 1'b0;
        rx_gap = 0;
        evt_stall = 0;
        evt_busy = 1'b1;
        rx_busy = 1'b1;
        resync = 1'b0;
        pressure_go = 1'b0;
        errors = 0;
        queued_count = 0;
        cycle_count = 0;
        max_len_cfg = MAX_PAYLOAD_RESET;
        win = '{default: '0};
        hdr_cnt = 0;
        in_pay = 1'b0;
        remaining = '0;
        cur_type = '0;
        cur_len = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_max_len();

        // Default limit: normal, empty and oversize frames, a slid header,
        // a payload cut by a new session and a header cut by one.
        queue_frame(1'b1, 8'h01, 32'd2, 2);
        queue_frame(1'b0, 8'hFF, 32'd0, 0);
        queue_frame(1'b0, 8'h00, 32'hFFFF_FFFF, 0);
        push_byte(8'h12, 1'b0);
        queue_frame(1'b0, 8'h03, 32'd1, 1);
        queue_frame(1'b0, 8'h80, MAX_PAYLOAD_RESET, 1);
        push_byte(MAGIC_FIRST, 1'b1);
        push_byte(MAGIC_SECOND, 1'b0);
        queue_frame(1'b1, 8'h02, MAX_PAYLOAD_RESET + 1, 0);
        queue_random(70);
        wait_idle();

        set_max_len(32'd0);
        queue_frame(1'b1, 8'h11, 32'd0, 0);
        queue_frame(1'b0, 8'h22, 32'd1, 0);
        queue_random(40);
        wait_idle();

        set_max_len(32'd5);
        queue_frame(1'b1, 8'h33, 32'd5, 5);
        queue_frame(1'b0, 8'h44, 32'd6, 0);
        queue_random(80);
        wait_idle();

        // Largest limit: any nonzero length is taken, so long payloads are cut short.
        // A long frame runs while the event side holds off.
        set_max_len(32'hFFFF_FFFF);
        queue_frame(1'b1, 8'h55, 32'hFFFF_FFFF, 2);
        pressure_go = 1'b1;
        queue_frame(1'b1, 8'h5A, 32'd120, 120);
        queue_random(40);
        wait_idle();

        set_max_len(MAX_PAYLOAD_RESET);
        queue_random(60);
        wait_idle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
